FILE: hw/rtl/three_tier_threshold_alert_top_defines.svh
// Assertion macros for the three-tier threshold alert block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef THREE_TIER_THRESHOLD_ALERT_TOP_DEFINES_SVH
`define THREE_TIER_THRESHOLD_ALERT_TOP_DEFINES_SVH

// same-cycle implication, idle during reset
`define TTTA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttta: same-cycle check failed");

// next-cycle implication, idle during reset
`define TTTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttta: next-cycle check failed");

`endif

FILE: hw/rtl/ttta_pkg.sv
// Shared widths, register indexes, reset values and types for the
// three-tier threshold alert block. No dependencies.
package ttta_pkg;

    localparam int LEVEL_W    = 48;   // usage levels and thresholds
    localparam int TIME_W     = 48;   // timestamps in ms
    localparam int MARGIN_W   = 16;   // Q0.16 hysteresis margin
    localparam int COOL_W     = 32;   // cooldown in ms
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_TIERS  = 3;
    localparam int TIER_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THR_TIER1   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_TIER2   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_TIER3   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd4;

    localparam logic [TIER_W-1:0] TIER_NORMAL = 2'd0;

    localparam logic [LEVEL_W-1:0]  THR_RESET    = {LEVEL_W{1'b1}};
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd6554;
    localparam logic [COOL_W-1:0]   COOL_RESET   = 32'd60000;

    // thr - floor(thr * margin / 2^16); the product never exceeds thr << 16
    function automatic logic [LEVEL_W-1:0] rearm_point(
        input logic [LEVEL_W-1:0]  thr,
        input logic [MARGIN_W-1:0] margin
    );
        logic [LEVEL_W+MARGIN_W-1:0] prod;
        prod = {{MARGIN_W{1'b0}}, thr} * {{LEVEL_W{1'b0}}, margin};
        return thr - prod[LEVEL_W+MARGIN_W-1:MARGIN_W];
    endfunction

    localparam logic [LEVEL_W-1:0] REARM_RESET = rearm_point(THR_RESET, MARGIN_RESET);

    typedef struct packed {
        logic [NUM_TIERS-1:0][LEVEL_W-1:0] thr;
        logic [NUM_TIERS-1:0][LEVEL_W-1:0] rearm;
        logic [COOL_W-1:0]                 cooldown;
    } cfg_t;

    typedef struct packed {
        logic [TIER_W-1:0] tier;
        logic              fired;
        logic [TIER_W-1:0] alert_tier;
    } result_t;

endpackage

FILE: hw/rtl/ttta_cfg.sv
// Configuration registers and registered per-tier re-arm points.
// Depends on ttta_pkg.
module ttta_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ttta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttta_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ttta_pkg::cfg_t                   cfg
);

    logic [ttta_pkg::NUM_TIERS-1:0][ttta_pkg::LEVEL_W-1:0] thr_reg;
    logic [ttta_pkg::NUM_TIERS-1:0][ttta_pkg::LEVEL_W-1:0] thr_next;
    logic [ttta_pkg::NUM_TIERS-1:0][ttta_pkg::LEVEL_W-1:0] rearm_reg;
    logic [ttta_pkg::NUM_TIERS-1:0][ttta_pkg::LEVEL_W-1:0] rearm_next;
    logic [ttta_pkg::MARGIN_W-1:0] margin_reg;
    logic [ttta_pkg::MARGIN_W-1:0] margin_next;
    logic [ttta_pkg::COOL_W-1:0]   cool_reg;
    logic [ttta_pkg::COOL_W-1:0]   cool_next;

    always_comb
    begin
        thr_next    = thr_reg;
        margin_next = margin_reg;
        cool_next   = cool_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ttta_pkg::REG_THR_TIER1:    thr_next[0] = cfg_data[ttta_pkg::LEVEL_W-1:0];
                ttta_pkg::REG_THR_TIER2:    thr_next[1] = cfg_data[ttta_pkg::LEVEL_W-1:0];
                ttta_pkg::REG_THR_TIER3:    thr_next[2] = cfg_data[ttta_pkg::LEVEL_W-1:0];
                ttta_pkg::REG_RESET_MARGIN: margin_next = cfg_data[ttta_pkg::MARGIN_W-1:0];
                ttta_pkg::REG_COOLDOWN:     cool_next   = cfg_data[ttta_pkg::COOL_W-1:0];
                default:                    ; // unknown index: ignored
            endcase
        end
    end

    // one 48x16 multiply per tier, from the threshold and margin registers into the re-arm registers
    always_comb
    begin
        for (int k = 0; k < ttta_pkg::NUM_TIERS; k++)
        begin
            rearm_next[k] = ttta_pkg::rearm_point(thr_reg[k], margin_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= {ttta_pkg::NUM_TIERS{ttta_pkg::THR_RESET}};
            rearm_reg  <= {ttta_pkg::NUM_TIERS{ttta_pkg::REARM_RESET}};
            margin_reg <= ttta_pkg::MARGIN_RESET;
            cool_reg   <= ttta_pkg::COOL_RESET;
        end
        else
        begin
            thr_reg    <= thr_next;
            rearm_reg  <= rearm_next;
            margin_reg <= margin_next;
            cool_reg   <= cool_next;
        end
    end

    assign cfg.thr      = thr_reg;
    assign cfg.rearm    = rearm_reg;
    assign cfg.cooldown = cool_reg;

endmodule

FILE: hw/rtl/ttta_core.sv
// Per-sample tier decision and per-tier arm/fire-time state.
// Depends on ttta_pkg.
module ttta_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [ttta_pkg::LEVEL_W-1:0]  used,
    input  logic [ttta_pkg::TIME_W-1:0]   now,
    input  ttta_pkg::cfg_t                cfg,
    output ttta_pkg::result_t             res
);

    logic [ttta_pkg::NUM_TIERS-1:0] armed_reg;
    logic [ttta_pkg::NUM_TIERS-1:0] armed_next;
    logic [ttta_pkg::NUM_TIERS-1:0] stamped_reg;
    logic [ttta_pkg::NUM_TIERS-1:0] stamped_next;
    logic [ttta_pkg::NUM_TIERS-1:0][ttta_pkg::TIME_W-1:0] last_reg;
    logic [ttta_pkg::NUM_TIERS-1:0][ttta_pkg::TIME_W-1:0] last_next;

    logic [ttta_pkg::NUM_TIERS-1:0] armed_now;
    logic [ttta_pkg::NUM_TIERS-1:0] meets;
    logic [ttta_pkg::NUM_TIERS-1:0] elapsed;
    logic [ttta_pkg::NUM_TIERS-1:0] sel;
    logic [ttta_pkg::NUM_TIERS-1:0] covered;
    logic [ttta_pkg::NUM_TIERS-1:0][ttta_pkg::TIME_W:0] diff;
    logic [ttta_pkg::TIER_W-1:0]    tier;
    logic                           fire;

    // re-arm, threshold test and cooldown test per tier, all in parallel
    always_comb
    begin
        for (int k = 0; k < ttta_pkg::NUM_TIERS; k++)
        begin
            armed_now[k] = armed_reg[k] | (used < cfg.rearm[k]);
            meets[k]     = used >= cfg.thr[k];
            diff[k]      = {1'b0, now} - {1'b0, last_reg[k]};
            // negative difference (time went back) never counts as elapsed for a stamped tier
            elapsed[k]   = !stamped_reg[k] ||
                           (!diff[k][ttta_pkg::TIME_W] &&
                            (diff[k][ttta_pkg::TIME_W-1:0] >=
                             {{(ttta_pkg::TIME_W-ttta_pkg::COOL_W){1'b0}}, cfg.cooldown}));
        end
    end

    // highest tier wins, even with unordered thresholds
    always_comb
    begin
        if (meets[2])
            tier = 2'd3;
        else if (meets[1])
            tier = 2'd2;
        else if (meets[0])
            tier = 2'd1;
        else
            tier = ttta_pkg::TIER_NORMAL;
    end

    always_comb
    begin
        for (int k = 0; k < ttta_pkg::NUM_TIERS; k++)
        begin
            sel[k] = (tier == ttta_pkg::TIER_W'(k + 1));
        end
        fire = |(sel & armed_now & elapsed);
        for (int k = 0; k < ttta_pkg::NUM_TIERS; k++)
        begin
            covered[k]      = fire && (tier > ttta_pkg::TIER_W'(k));
            armed_next[k]   = covered[k] ? 1'b0 : armed_now[k];
            stamped_next[k] = stamped_reg[k] | covered[k];
            last_next[k]    = covered[k] ? now : last_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= '1;
            stamped_reg <= '0;
        end
        else if (step)
        begin
            armed_reg   <= armed_next;
            stamped_reg <= stamped_next;
        end
    end

    // fire times are only read once stamped; no reset needed
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            last_reg <= last_next;
        end
    end

    assign res.tier       = tier;
    assign res.fired      = fire;
    assign res.alert_tier = fire ? tier : ttta_pkg::TIER_NORMAL;

endmodule

FILE: hw/rtl/three_tier_threshold_alert_top.sv
// Top level of the three-tier threshold alert: input register, decision
// core, result register. Depends on ttta_pkg, ttta_cfg, ttta_core and the defines header.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   in      | to block  | in_valid / in_stall  | used_bytes, now_ms
//   out     | from block| out_valid / out_stall| current_tier, alert_fired, alert_tier
//   cfg     | to block  | cfg_we               | cfg_index, cfg_data
//
// One sample per cycle sustained while out_stall is low; a sample transferred in
// passes from the input register through the core into the result register,
// from which its result transfers out once out_stall is low.
// The per-tier arm and fire-time state updates on every step and feeds the next sample.
// Re-arm points are registered from the threshold and margin registers after a write.
// Reset (rst_n low, async) arms all tiers, clears fire stamps and loads
// the default thresholds, margin and cooldown. No clearing pass.
// A stalled result holds; the input register still takes a sample behind it.
`include "three_tier_threshold_alert_top_defines.svh"

module three_tier_threshold_alert_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // sample channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ttta_pkg::LEVEL_W-1:0]     used_bytes,
    input  logic [ttta_pkg::TIME_W-1:0]      now_ms,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ttta_pkg::TIER_W-1:0]      current_tier,
    output logic                             alert_fired,
    output logic [ttta_pkg::TIER_W-1:0]      alert_tier,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [ttta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttta_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ttta_pkg::cfg_t    cfg;
    ttta_pkg::result_t core_res;

    logic                            s1_valid_reg;
    logic                            s1_valid_next;
    logic [ttta_pkg::LEVEL_W-1:0]    s1_used_reg;
    logic [ttta_pkg::TIME_W-1:0]     s1_now_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    ttta_pkg::result_t               out_res_reg;

    // last result transferred out, kept for the escalation check
    logic                            prev_fired_reg;
    logic [ttta_pkg::TIER_W-1:0]     prev_tier_reg;

    logic in_xfer;
    logic out_xfer;
    logic advance;
    logic step;
    logic alert_tier_ok;
    logic fire_repeat;

    // result register free or emptying this cycle
    assign advance  = !out_valid_reg || !out_stall;
    // sample in the input register moves through the core and updates state
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (step)
            s1_valid_next = 1'b0;

        out_valid_next = advance ? step : out_valid_reg;
    end

    ttta_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ttta_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .used  (s1_used_reg),
        .now   (s1_now_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_fired_reg <= 1'b0;
            prev_tier_reg  <= ttta_pkg::TIER_NORMAL;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_xfer)
            begin
                prev_fired_reg <= out_res_reg.fired;
                prev_tier_reg  <= out_res_reg.alert_tier;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_used_reg <= used_bytes;
            s1_now_reg  <= now_ms;
        end
        if (step)
        begin
            out_res_reg <= core_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_tier = out_res_reg.tier;
    assign alert_fired  = out_res_reg.fired;
    assign alert_tier   = out_res_reg.alert_tier;

    // alert tier follows the current tier exactly when an alert fired
    assign alert_tier_ok = out_res_reg.fired
        ? (out_res_reg.alert_tier == out_res_reg.tier &&
           out_res_reg.tier != ttta_pkg::TIER_NORMAL)
        : (out_res_reg.alert_tier == ttta_pkg::TIER_NORMAL);
    // result on offer fired and so did the one transferred just before it
    assign fire_repeat = out_valid_reg && out_res_reg.fired && prev_fired_reg;

    `TTTA_ASSERT_IMPLY(a_alert_tier_match, out_valid_reg, alert_tier_ok)
    // a fire disarms its tier and all below, so a fire right after a fire must escalate
    `TTTA_ASSERT_IMPLY(a_fire_escalates, fire_repeat, out_res_reg.alert_tier > prev_tier_reg)
    // every sample taken through the core lands in the result register
    `TTTA_ASSERT_NEXT(a_step_lands, step, out_valid_reg)
    // the input side only stalls while its register holds a sample
    `TTTA_ASSERT_IMPLY(a_stall_only_full, in_stall, s1_valid_reg && out_valid_reg)

endmodule

FILE: verif/ttta_alert_checker.sv
`timescale 1ns / 100ps
// Scoreboard for three_tier_threshold_alert_top. It watches the sample, result
// and register write ports, predicts every result and compares. Needs ttta_pkg.
module ttta_alert_checker
    import ttta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [LEVEL_W-1:0]    used_bytes,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [TIER_W-1:0]     current_tier,
    input  logic                  alert_fired,
    input  logic [TIER_W-1:0]     alert_tier,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    err_count,
    output int                    outstanding
);

    // shadow of the register file and of the per-tier alarm state
    logic [LEVEL_W-1:0]  thr_q [NUM_TIERS];
    logic [MARGIN_W-1:0] margin_q;
    logic [COOL_W-1:0]   cool_q;
    logic                armed_q [NUM_TIERS];
    logic                stamped_q [NUM_TIERS];
    logic [TIME_W-1:0]   stamp_q [NUM_TIERS];

    result_t             pending_verdicts [$];
    int                  mismatch_n;

    // level below which a tier re-arms
    function automatic logic [LEVEL_W-1:0] rearm_level(
        input logic [LEVEL_W-1:0]  thr,
        input logic [MARGIN_W-1:0] frac
    );
        logic [63:0] drop;
        drop = (64'(thr) * 64'(frac)) >> MARGIN_W;
        return thr - drop[LEVEL_W-1:0];
    endfunction

    task automatic classify_sample(
        input  logic [LEVEL_W-1:0] used,
        input  logic [TIME_W-1:0]  now,
        output result_t            verdict
    );
        int     hit;
        longint since;
        logic   elapsed;
        hit = 0;
        for (int k = 0; k < NUM_TIERS; k++)
            if (used < rearm_level(thr_q[k], margin_q))
                armed_q[k] = 1'b1;
        // highest tier wins, even with unordered thresholds
        for (int k = NUM_TIERS - 1; k >= 0 && hit == 0; k--)
            if (used >= thr_q[k])
                hit = k + 1;
        verdict.tier       = hit[TIER_W-1:0];
        verdict.fired      = 1'b0;
        verdict.alert_tier = TIER_NORMAL;
        if (hit != 0)
        begin
            elapsed = !stamped_q[hit-1];
            if (!elapsed)
            begin
                // exact signed difference, negative when time ran backwards
                since   = $signed({16'h0, now}) - $signed({16'h0, stamp_q[hit-1]});
                elapsed = since >= $signed({32'h0, cool_q});
            end
            if (armed_q[hit-1] && elapsed)
            begin
                for (int k = 0; k < hit; k++)
                begin
                    armed_q[k]   = 1'b0;
                    stamped_q[k] = 1'b1;
                    stamp_q[k]   = now;
                end
                verdict.fired      = 1'b1;
                verdict.alert_tier = hit[TIER_W-1:0];
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_TIERS; k++)
            begin
                thr_q[k]     = THR_RESET;
                armed_q[k]   = 1'b1;
                stamped_q[k] = 1'b0;
                stamp_q[k]   = '0;
            end
            margin_q = MARGIN_RESET;
            cool_q   = COOL_RESET;
            pending_verdicts.delete();
            mismatch_n = 0;
            err_count   <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.tier       = current_tier;
                got.fired      = alert_fired;
                got.alert_tier = alert_tier;
                if (pending_verdicts.size() == 0)
                begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("%0t ttta: unexpected result tier %0d fired %0b alert %0d",
                                 $realtime, got.tier, got.fired, got.alert_tier);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (got.tier != want.tier || got.fired != want.fired ||
                        got.alert_tier != want.alert_tier)
                    begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                            $display({"%0t ttta: mismatch, expected tier %0d fired %0b",
                                      " alert %0d, got tier %0d fired %0b alert %0d"},
                                     $realtime, want.tier, want.fired, want.alert_tier,
                                     got.tier, got.fired, got.alert_tier);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THR_TIER1:    thr_q[0] = cfg_data[LEVEL_W-1:0];
                    REG_THR_TIER2:    thr_q[1] = cfg_data[LEVEL_W-1:0];
                    REG_THR_TIER3:    thr_q[2] = cfg_data[LEVEL_W-1:0];
                    REG_RESET_MARGIN: margin_q = cfg_data[MARGIN_W-1:0];
                    REG_COOLDOWN:     cool_q   = cfg_data[COOL_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                classify_sample(used_bytes, now_ms, want);
                pending_verdicts.push_back(want);
            end
            err_count   <= mismatch_n;
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

FILE: verif/tb_three_tier_threshold_alert_top.sv
`timescale 1ns / 100ps
// Testbench top for three_tier_threshold_alert_top: clock, reset, register
// settings and sample traffic. Needs ttta_pkg, the block and ttta_alert_checker.
module tb_three_tier_threshold_alert_top;
    import ttta_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 76;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = {LEVEL_W{1'b1}};
    localparam logic [TIME_W-1:0]   TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [MARGIN_W-1:0] MARGIN_MAX = {MARGIN_W{1'b1}};
    localparam logic [COOL_W-1:0]   COOL_MAX   = {COOL_W{1'b1}};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [LEVEL_W-1:0]    used_bytes;
    logic [TIME_W-1:0]     now_ms;
    logic                  out_valid;
    logic                  out_stall;
    logic [TIER_W-1:0]     current_tier;
    logic                  alert_fired;
    logic [TIER_W-1:0]     alert_tier;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    err_count;
    int                    outstanding;

    // stimulus-side copy of the current setting, only used to aim samples
    logic [LEVEL_W-1:0]    thr_cfg [NUM_TIERS];
    logic [MARGIN_W-1:0]   margin_cfg;
    logic [COOL_W-1:0]     cool_cfg;
    logic [TIME_W-1:0]     wall_ms;
    logic                  idle_on;   // enables sender gaps and result stalls

    three_tier_threshold_alert_top dut (.*);

    ttta_alert_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One sample transfer. An optional gap drops valid first; once valid is up the
    // payload holds until the edge where in_stall is low.
    task automatic send_sample(input logic [LEVEL_W-1:0] u, input logic [TIME_W-1:0] t);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        used_bytes <= u;
        now_ms     <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Sender holds off until every expected result has come back. It waits first so
    // the checker has counted the last transfer, then lets the pipe settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes all five registers plus one unused index, which the block must ignore.
    // Narrow registers get junk in the unused upper data bits. Re-arm points are
    // registered from the written values, so wait before the next sample.
    task automatic apply_setting(
        input logic [LEVEL_W-1:0]  t1,
        input logic [LEVEL_W-1:0]  t2,
        input logic [LEVEL_W-1:0]  t3,
        input logic [MARGIN_W-1:0] m,
        input logic [COOL_W-1:0]   c
    );
        cfg_we    <= 1'b1;
        cfg_index <= REG_THR_TIER1;
        cfg_data  <= t1;
        @(posedge clk);
        cfg_index <= REG_THR_TIER2;
        cfg_data  <= t2;
        @(posedge clk);
        cfg_index <= REG_THR_TIER3;
        cfg_data  <= t3;
        @(posedge clk);
        cfg_index <= REG_RESET_MARGIN;
        cfg_data  <= {$urandom, m};
        @(posedge clk);
        cfg_index <= REG_COOLDOWN;
        cfg_data  <= {16'($urandom), c};
        @(posedge clk);
        cfg_index <= REG_COOLDOWN + 3'd1 + 3'($urandom_range(0, 2));
        cfg_data  <= {$urandom, 16'($urandom)};
        @(posedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
        thr_cfg[0] = t1;
        thr_cfg[1] = t2;
        thr_cfg[2] = t3;
        margin_cfg = m;
        cool_cfg   = c;
    endtask

    // Usage aimed at one tier: exactly on the threshold, just under or over it,
    // under the re-arm point, or inside the hysteresis band; plus zero, full scale and noise.
    function automatic logic [LEVEL_W-1:0] pick_usage();
        logic [LEVEL_W-1:0] t;
        logic [LEVEL_W-1:0] low;
        logic [63:0]        drop;
        t    = thr_cfg[$urandom_range(0, NUM_TIERS - 1)];
        drop = (64'(t) * 64'(margin_cfg)) >> MARGIN_W;
        low  = t - drop[LEVEL_W-1:0];
        case ($urandom_range(0, 15))
            0:       return {16'($urandom), $urandom};
            1:       return '0;
            2:       return LEVEL_MAX;
            3, 4:    return t;
            5, 6:    return (t == 0) ? t : t - 1;
            7, 8:    return (t > LEVEL_MAX - 64) ? LEVEL_MAX : t + $urandom_range(1, 64);
            9, 10:   return (low > 64) ? low - $urandom_range(1, 64) : '0;
            default: return (drop == 0) ? t : low + LEVEL_W'({$urandom, $urandom} % drop);
        endcase
    endfunction

    // Result-side backpressure: random bursts of stalled cycles while idling is on.
    initial
    begin : result_backpressure
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Any transfer on either channel resets the count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL three_tier_threshold_alert_top");
        $finish;
    end

    initial
    begin : stimulus
        logic [LEVEL_W-1:0]  next_thr [NUM_TIERS];
        logic [LEVEL_W-1:0]  base;
        logic [MARGIN_W-1:0] next_margin;
        logic [COOL_W-1:0]   next_cool;
        int                  style;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        used_bytes <= '0;
        now_ms     <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_THR_TIER1;
        cfg_data   <= '0;
        idle_on    = 1'b1;
        wall_ms    = '0;
        for (int k = 0; k < NUM_TIERS; k++)
            thr_cfg[k] = THR_RESET;
        margin_cfg = MARGIN_RESET;
        cool_cfg   = COOL_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: all thresholds at the top, so only a full-scale sample
        // reaches a tier, and tier 3 wins the tie. First alert of a tier never waits.
        send_sample('0, '0);
        send_sample(LEVEL_MAX, '0);
        send_sample(LEVEL_MAX, TIME_MAX);   // still above the re-arm point, stays quiet
        wait_drained();

        // Ordered thresholds, half-scale hysteresis, no cooldown.
        // Re-arm points land at 500, 1000 and 1500.
        apply_setting(48'd1000, 48'd2000, 48'd3000, 16'h8000, '0);
        send_sample(48'd0, 48'd100);      // re-arms every tier
        send_sample(48'd1500, 48'd200);   // tier 1 fires
        send_sample(48'd2500, 48'd300);   // tier 2 fires
        send_sample(48'd3500, 48'd400);   // tier 3 fires, all disarmed
        send_sample(48'd3500, 48'd400);
        send_sample(48'd1200, 48'd500);   // inside the band, tier 1 stays disarmed
        send_sample(48'd400, 48'd600);    // normal, re-arms all
        send_sample(48'd1000, 48'd50);    // clock ran backwards: no alert
        send_sample(48'd1000, 48'd400);   // zero elapsed meets zero cooldown
        wait_drained();

        // Extremes: tier 1 at zero never re-arms, full-scale margin, longest cooldown.
        apply_setting('0, {1'b1, 47'd0}, LEVEL_MAX, MARGIN_MAX, COOL_MAX);
        send_sample('0, '0);
        send_sample(48'd5, TIME_MAX);
        send_sample({1'b1, 47'd0}, 48'd1000);        // cooldown not yet over
        send_sample(LEVEL_MAX, 48'd1000 + COOL_MAX); // long enough since the last one
        send_sample(48'd123, 48'd2);
        wait_drained();

        // Unordered thresholds: tier 3 is tested first even though it is the lowest.
        apply_setting(48'd5000, 48'd3000, 48'd1000, '0, 32'd10);
        send_sample(48'd0, 48'd10000);
        send_sample(48'd4000, 48'd10020);
        send_sample(48'd2000, 48'd10040);
        send_sample(48'd6000, 48'd10060);
        wait_drained();

        // Random settings, each followed by a burst of aimed samples. Phase 3 and the
        // last two run with no gaps or stalls.
        wall_ms = 48'd20000;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            style = $urandom_range(0, 3);
            base  = LEVEL_W'($urandom_range(1000, 1 << 20));
            for (int k = 0; k < NUM_TIERS; k++)
            begin
                case (style)
                    0:       next_thr[k] = base * (k + 1);
                    1:       next_thr[k] = LEVEL_W'($urandom_range(0, 1 << 20));
                    2:       next_thr[k] = {16'($urandom), $urandom};
                    default: next_thr[k] = LEVEL_MAX - $urandom_range(0, 4096) * (3 - k);
                endcase
            end
            case ($urandom_range(0, 5))
                0:       next_margin = '0;
                1:       next_margin = MARGIN_MAX;
                default: next_margin = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       next_cool = '0;
                1:       next_cool = COOL_MAX;
                2, 3:    next_cool = $urandom_range(0, 2000);
                default: next_cool = $urandom;
            endcase
            apply_setting(next_thr[0], next_thr[1], next_thr[2], next_margin, next_cool);
            idle_on = (p != 3) && (p < RANDOM_PHASES - 2);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // time mostly moves forward; sometimes it lands right on the cooldown
                // edge, steps back, or jumps anywhere
                case ($urandom_range(0, 19))
                    0:       wall_ms = {16'($urandom), $urandom};
                    1:       wall_ms = wall_ms - $urandom_range(0, 3000);
                    2, 3:    wall_ms = wall_ms + cool_cfg - 1 + $urandom_range(0, 2);
                    default: wall_ms = wall_ms + $urandom_range(0, 1500);
                endcase
                send_sample(pick_usage(), wall_ms);
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("PASS three_tier_threshold_alert_top");
        else
            $display("FAIL three_tier_threshold_alert_top");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ttta_pkg.sv
hw/rtl/ttta_cfg.sv
hw/rtl/ttta_core.sv
hw/rtl/three_tier_threshold_alert_top.sv
verif/ttta_alert_checker.sv
verif/tb_three_tier_threshold_alert_top.sv
